// ===== rtl/pfcx_pkg.sv =====
// Package for the prime factor count / XOR core.
// Holds shared constants, the sequencer state type and divider control and status structs.
// No dependencies.
package pfcx_pkg;

    localparam int DEFAULT_VALUE_BITS = 17;
    localparam int CNT_BITS           = 5;
    // Quotient bits the divider resolves per clock cycle.
    localparam int DIV_STEP_BITS      = 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_START,
        S_DIV_WAIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/pfcx_if.sv =====
// Valid/ready channel interfaces for the prime factor count / XOR core.
// Depends on nothing; the value width is an interface parameter.
interface pfcx_in_if #(
    parameter int VALUE_BITS = 17
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface pfcx_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] factor_count;
    logic       first_wins;
    logic       set_done;

    modport source (output valid, output factor_count, output first_wins,
                    output set_done, input ready);
    modport sink   (input valid, input factor_count, input first_wins,
                    input set_done, output ready);
endinterface

// ===== rtl/prime_factor_count_xor_core.sv =====
// Sequence: a divisor that leaves a remainder passes the bound check, the divider start,
// the divider steps and its done strobe; each factor found passes the divider start, steps
// and done strobe again. Entry and exit pass through the idle and finish states.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: synchronous active-low i_rst_n clears the sequencer, the running XOR and o_out.valid.
module prime_factor_count_xor_core
    import pfcx_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfcx_in_if.sink     i_in,
    pfcx_out_if.source  o_out
);

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_rem, n_rem;
    logic [VALUE_BITS-1:0] r_d, n_d;
    logic [VALUE_BITS:0]   r_d_sq, n_d_sq;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                  r_last, n_last;
    logic [CNT_BITS-1:0]   r_xor, n_xor;
    logic                  r_out_valid, n_out_valid;
    logic [CNT_BITS-1:0]   r_out_cnt, n_out_cnt;
    logic                  r_out_wins, n_out_wins;
    logic                  r_out_last, n_out_last;

    t_div_ctl              div_ctl;
    t_div_stat             div_stat;
    logic [VALUE_BITS-1:0] div_quo;
    logic [VALUE_BITS-1:0] div_rem;

    pfcx_div #(
        .WIDTH     (VALUE_BITS),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (r_rem),
        .i_divisor   (r_d),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        logic [CNT_BITS-1:0] final_cnt;
        logic [CNT_BITS-1:0] sum;
        n_state     = r_state;
        n_rem       = r_rem;
        n_d         = r_d;
        n_d_sq      = r_d_sq;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_xor       = r_xor;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_cnt   = r_out_cnt;
        n_out_wins  = r_out_wins;
        n_out_last  = r_out_last;
        div_ctl     = '0;
        final_cnt   = r_cnt + CNT_BITS'(r_rem > VALUE_BITS'(1));
        sum         = r_xor ^ final_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_rem   = i_in.value;
                    n_last  = i_in.is_last;
                    n_d     = VALUE_BITS'(2);
                    n_d_sq  = (VALUE_BITS + 1)'(4);
                    n_cnt   = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_d_sq <= {1'b0, r_rem}) begin
                    n_state = S_DIV_START;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV_START: begin
                div_ctl.start = 1'b1;
                n_state       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    if (div_rem == '0) begin
                        // Keep dividing by the same divisor until it no longer fits.
                        n_rem   = div_quo;
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_DIV_START;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1 keeps the square without a multiplier.
                        n_d     = r_d + 1'b1;
                        n_d_sq  = r_d_sq + {r_d, 1'b0} + 1'b1;
                        n_state = S_CHECK;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_cnt   = final_cnt;
                    n_out_wins  = (sum != '0);
                    n_out_last  = r_last;
                    n_xor       = r_last ? '0 : sum;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_xor       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_xor       <= n_xor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_d        <= n_d;
        r_d_sq     <= n_d_sq;
        r_cnt      <= n_cnt;
        r_last     <= n_last;
        r_out_cnt  <= n_out_cnt;
        r_out_wins <= n_out_wins;
        r_out_last <= n_out_last;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.factor_count = r_out_cnt;
    assign o_out.first_wins   = r_out_wins;
    assign o_out.set_done     = r_out_last;

    // The incrementally tracked square must match the divisor at every bound check.
    a_square_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |->
            ({{(VALUE_BITS - 1){1'b0}}, r_d_sq} == ({{VALUE_BITS{1'b0}}, r_d}
                                                   * {{VALUE_BITS{1'b0}}, r_d})))
        else $error("divisor square out of step with divisor");

    // The divider is never restarted while a division is in flight.
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A new result appears only when the sequencer leaves the finish state.
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> ($past(r_state) == S_FINISH))
        else $error("result loaded outside the finish state");

    // Waiting on the divider always has a division running or just completed.
    a_wait_has_division: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_WAIT) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");

endmodule

// ===== rtl/pfcx_div.sv =====
// Iterative restoring divider, STEP_BITS quotient bits per cycle while busy.
// Depends on pfcx_pkg for the control and status structs.
module pfcx_div
    import pfcx_pkg::*;
#(
    parameter int WIDTH     = DEFAULT_VALUE_BITS,
    parameter int STEP_BITS = DIV_STEP_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctl         i_ctl,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);

    localparam int CYCLES = (WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD    = CYCLES * STEP_BITS;
    localparam int CW     = $clog2(CYCLES + 1);

    logic [WIDTH-1:0] r_acc, n_acc;
    logic [PAD-1:0]   r_quo, n_quo;
    logic [WIDTH-1:0] r_divisor;
    logic [CW-1:0]    r_cyc;
    logic             r_busy;
    logic             r_done;

    // Partial remainder shifts in one dividend bit per step; the quotient
    // bit takes the vacated low position of the dividend/quotient register.
    always_comb begin
        logic [WIDTH:0]   sh;
        logic [WIDTH-1:0] acc;
        logic [PAD-1:0]   quo;
        acc = r_acc;
        quo = r_quo;
        sh  = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            sh  = {acc, quo[PAD-1]};
            quo = {quo[PAD-2:0], 1'b0};
            if (sh >= {1'b0, r_divisor}) begin
                sh     = sh - {1'b0, r_divisor};
                quo[0] = 1'b1;
            end
            acc = sh[WIDTH-1:0];
        end
        n_acc = acc;
        n_quo = quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cyc  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cyc  <= CW'(CYCLES);
            end else if (r_busy) begin
                r_cyc <= r_cyc - 1'b1;
                if (r_cyc == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc     <= '0;
            r_quo     <= PAD'(i_dividend);
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_quo <= n_quo;
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo[WIDTH-1:0];
    assign o_remainder  = r_acc;

endmodule
